// File: rtl/jhmd_pkg.sv
package jhmd_pkg;

  localparam int MAX_JETS_DEF  = 64;
  localparam int LEAD_JETS_DEF = 4;
  localparam int REPORT_JETS   = 4;

  localparam int CORDIC_STEPS = 14;
  localparam int SQRT_STEPS   = 24;
  localparam int STEP_W       = 5;

  localparam logic [15:0] PT_GAIN = 16'd39797;
  localparam logic [21:0] SUM_MAX = 22'h3FFFFF;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PT_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HT_ETA_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MHT_ETA_LIMIT = 2'd2;

  localparam logic [15:0] PT_THRESHOLD_RST  = 16'd120;
  localparam logic [9:0]  HT_ETA_LIMIT_RST  = 10'd240;
  localparam logic [9:0]  MHT_ETA_LIMIT_RST = 10'd500;

  // Arctangent of 2^-i in 16-bit turn units.
  function automatic logic [13:0] atan_step(input logic [3:0] i);
    logic [13:0] r;
    case (i)
      4'd0:    r = 14'd8192;
      4'd1:    r = 14'd4836;
      4'd2:    r = 14'd2555;
      4'd3:    r = 14'd1297;
      4'd4:    r = 14'd651;
      4'd5:    r = 14'd326;
      4'd6:    r = 14'd163;
      4'd7:    r = 14'd81;
      4'd8:    r = 14'd41;
      4'd9:    r = 14'd20;
      4'd10:   r = 14'd10;
      4'd11:   r = 14'd5;
      4'd12:   r = 14'd3;
      4'd13:   r = 14'd1;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic              load_rot;
    logic              step_rot;
    logic              acc;
    logic              load_vec;
    logic              step_vec;
    logic              sq_y;
    logic              load_sqrt;
    logic              step_sqrt;
    logic              publish;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic mht_go;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/jhmd_if.sv
interface jhmd_jet_if;
  logic               valid;
  logic               ready;
  logic [15:0]        jet_pt;
  logic signed [10:0] jet_eta;
  logic [9:0]         jet_phi;
  logic               jet_present;
  logic               last_in_event;
  modport source(output valid, jet_pt, jet_eta, jet_phi, jet_present, last_in_event,
                 input ready);
  modport sink(input valid, jet_pt, jet_eta, jet_phi, jet_present, last_in_event,
               output ready);
endinterface

interface jhmd_res_if;
  logic        valid;
  logic        ready;
  logic [6:0]  jet_count;
  logic [21:0] ht_sum;
  logic [21:0] mht_magnitude;
  logic [2:0]  lead_count;
  logic [9:0]  dphi_first;
  logic [9:0]  dphi_second;
  logic [9:0]  dphi_third;
  logic [9:0]  dphi_fourth;
  logic        overflow;
  modport source(output valid, jet_count, ht_sum, mht_magnitude, lead_count, dphi_first,
                 dphi_second, dphi_third, dphi_fourth, overflow, input ready);
  modport sink(input valid, jet_count, ht_sum, mht_magnitude, lead_count, dphi_first,
               dphi_second, dphi_third, dphi_fourth, overflow, output ready);
endinterface

interface jhmd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [jhmd_pkg::CFG_IDX_W-1:0]      index;
  logic [jhmd_pkg::CFG_DATA_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/jet_ht_mht_deltaphi.sv
// Jet HT / MHT / delta-phi: takes one jet request per item and, on the item
// marked last_in_event, returns one result with the HT jet count, the scalar
// pt sum, the rounded magnitude of the jet vector sum and |delta phi| between
// that sum and each of the first four jets kept for it. An item that does
// not enter the vector sum needs no rotation; one that does runs the
// 14-step CORDIC rotation that turns pt and phi into components.
// Closing an event runs 14 CORDIC vectoring steps for the sum angle, two
// 24x24 squarings and a 24-step digit-by-digit square root, one after
// another. A finished result waits in an output register; the next
// event is taken only once that register is free to load the result before
// it. Configuration writes are accepted every cycle and take effect on the
// next item.
module jet_ht_mht_deltaphi #(
  parameter int MAX_JETS  = jhmd_pkg::MAX_JETS_DEF,
  parameter int LEAD_JETS = jhmd_pkg::LEAD_JETS_DEF
) (
  input logic         clk,
  input logic         rst,
  jhmd_jet_if.sink    jet,
  jhmd_res_if.source  result,
  jhmd_cfg_if.sink    cfg
);

  logic [15:0] pt_threshold;
  logic [9:0]  ht_eta_limit;
  logic [9:0]  mht_eta_limit;

  logic           in_ready;
  logic           accept;
  jhmd_pkg::cmd_t cmd;
  jhmd_pkg::sts_t sts;

  // Config writes land directly in registers; never stall the port.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_threshold  <= jhmd_pkg::PT_THRESHOLD_RST;
      ht_eta_limit  <= jhmd_pkg::HT_ETA_LIMIT_RST;
      mht_eta_limit <= jhmd_pkg::MHT_ETA_LIMIT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        jhmd_pkg::REG_PT_THRESHOLD:  pt_threshold  <= cfg.data;
        jhmd_pkg::REG_HT_ETA_LIMIT:  ht_eta_limit  <= cfg.data[9:0];
        jhmd_pkg::REG_MHT_ETA_LIMIT: mht_eta_limit <= cfg.data[9:0];
        default: ;
      endcase
    end
  end

  // Take a jet request only while the sequencer is idle.
  assign jet.ready = in_ready;
  assign accept    = jet.valid && in_ready;

  jhmd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_last  (jet.last_in_event),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  jhmd_dp #(
    .MAX_JETS  (MAX_JETS),
    .LEAD_JETS (LEAD_JETS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .jet_pt        (jet.jet_pt),
    .jet_eta       (jet.jet_eta),
    .jet_phi       (jet.jet_phi),
    .jet_present   (jet.jet_present),
    .pt_threshold  (pt_threshold),
    .ht_eta_limit  (ht_eta_limit),
    .mht_eta_limit (mht_eta_limit),
    .cmd           (cmd),
    .out_ready     (result.ready),
    .sts           (sts),
    .out_valid     (result.valid),
    .jet_count     (result.jet_count),
    .ht_sum        (result.ht_sum),
    .mht_magnitude (result.mht_magnitude),
    .lead_count    (result.lead_count),
    .dphi_first    (result.dphi_first),
    .dphi_second   (result.dphi_second),
    .dphi_third    (result.dphi_third),
    .dphi_fourth   (result.dphi_fourth),
    .overflow      (result.overflow)
  );

  // The end of an event always starts the close-out sequence.
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    accept && jet.last_in_event |=> !in_ready)
    else $error("input taken right after an event end");

  // No request is taken while any iterative unit is stepping.
  a_idle_excl: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !(cmd.step_rot || cmd.step_vec || cmd.step_sqrt || cmd.publish))
    else $error("input ready while datapath busy");

  // A result is loaded only when the output register is free.
  a_pub_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!result.valid || result.ready))
    else $error("result overwritten before taken");

endmodule

// File: rtl/jhmd_ctrl.sv
module jhmd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic           in_last,
  input  jhmd_pkg::sts_t sts,
  output logic           in_ready,
  output jhmd_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_ROT, S_ACC, S_VLOAD, S_VEC, S_SQY, S_SLOAD, S_SQRT, S_PUB
  } state_t;

  localparam logic [jhmd_pkg::STEP_W-1:0] ROT_LAST  =
    jhmd_pkg::STEP_W'(jhmd_pkg::CORDIC_STEPS - 1);
  localparam logic [jhmd_pkg::STEP_W-1:0] SQRT_LAST =
    jhmd_pkg::STEP_W'(jhmd_pkg::SQRT_STEPS - 1);

  state_t                      state;
  logic [jhmd_pkg::STEP_W-1:0] cnt;
  logic                        last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      last_q <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            last_q <= in_last;
            if (sts.mht_go) state <= S_LOAD;
            else if (in_last) state <= S_VLOAD;
          end
        end
        S_LOAD: begin
          cnt   <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          cnt <= cnt + 1'b1;
          if (cnt == ROT_LAST) state <= S_ACC;
        end
        S_ACC: state <= last_q ? S_VLOAD : S_IDLE;
        S_VLOAD: begin
          cnt   <= '0;
          state <= S_VEC;
        end
        S_VEC: begin
          cnt <= cnt + 1'b1;
          if (cnt == ROT_LAST) state <= S_SQY;
        end
        S_SQY: state <= S_SLOAD;
        S_SLOAD: begin
          cnt   <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          cnt <= cnt + 1'b1;
          if (cnt == SQRT_LAST) state <= S_PUB;
        end
        S_PUB: begin
          if (sts.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready      = (state == S_IDLE);
    cmd           = '0;
    cmd.step      = cnt;
    cmd.load_rot  = (state == S_LOAD);
    cmd.step_rot  = (state == S_ROT);
    cmd.acc       = (state == S_ACC);
    cmd.load_vec  = (state == S_VLOAD);
    cmd.step_vec  = (state == S_VEC);
    cmd.sq_y      = (state == S_SQY);
    cmd.load_sqrt = (state == S_SLOAD);
    cmd.step_sqrt = (state == S_SQRT);
    cmd.publish   = (state == S_PUB) && sts.out_free;
  end

endmodule

// File: rtl/jhmd_dp.sv
module jhmd_dp #(
  parameter int MAX_JETS  = jhmd_pkg::MAX_JETS_DEF,
  parameter int LEAD_JETS = jhmd_pkg::LEAD_JETS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [15:0]        jet_pt,
  input  logic signed [10:0] jet_eta,
  input  logic [9:0]         jet_phi,
  input  logic               jet_present,
  input  logic [15:0]        pt_threshold,
  input  logic [9:0]         ht_eta_limit,
  input  logic [9:0]         mht_eta_limit,
  input  jhmd_pkg::cmd_t     cmd,
  input  logic               out_ready,
  output jhmd_pkg::sts_t     sts,
  output logic               out_valid,
  output logic [6:0]         jet_count,
  output logic [21:0]        ht_sum,
  output logic [21:0]        mht_magnitude,
  output logic [2:0]         lead_count,
  output logic [9:0]         dphi_first,
  output logic [9:0]         dphi_second,
  output logic [9:0]         dphi_third,
  output logic [9:0]         dphi_fourth,
  output logic               overflow
);

  localparam int SEEN_W = $clog2(MAX_JETS + 2);
  localparam int LK_W   = $clog2(LEAD_JETS + 1);
  localparam int LIDX_W = (LEAD_JETS > 1) ? $clog2(LEAD_JETS) : 1;
  localparam logic [SEEN_W-1:0] SEEN_MAX  = SEEN_W'(MAX_JETS);
  localparam logic [SEEN_W-1:0] SEEN_OVER = SEEN_W'(MAX_JETS + 1);
  localparam logic [LK_W-1:0]   LK_MAX    = LK_W'(LEAD_JETS);

  // event state
  logic signed [23:0] sum_x, sum_y;
  logic [21:0]        scalar_sum;
  logic [6:0]         selected_count;
  logic [SEEN_W-1:0]  items_seen;
  logic [LK_W-1:0]    lead_kept;
  logic [9:0]         lead_phi [LEAD_JETS];

  // jet stage
  logic [31:0]        prod;
  logic [9:0]         phi_q;
  logic signed [17:0] a_fold;
  logic               neg_q;
  logic signed [27:0] rx, ry;
  logic signed [17:0] ra;

  // event close
  logic signed [34:0] vx, vy;
  logic [15:0]        vz;
  logic               vzero;
  logic signed [47:0] sqx, sqy;
  logic [47:0]        nsh;
  logic [25:0]        rem;
  logic [23:0]        root;

  // item selection
  logic [10:0]        eta_u, aeta;
  logic               room, pt_pass, ht_go, mht_go;
  logic [22:0]        scalar_add;
  logic signed [15:0] a16;
  logic signed [17:0] a_ext;

  assign eta_u   = unsigned'(jet_eta);
  assign aeta    = jet_eta[10] ? (~eta_u + 11'd1) : eta_u;
  assign room    = items_seen < SEEN_MAX;
  assign pt_pass = jet_pt > pt_threshold;
  assign ht_go   = jet_present && room && pt_pass && (aeta < {1'b0, ht_eta_limit});
  assign mht_go  = jet_present && room && pt_pass && (aeta < {1'b0, mht_eta_limit});
  assign scalar_add = {1'b0, scalar_sum} + {7'd0, jet_pt};
  assign a16     = signed'({~jet_phi[9], jet_phi[8:0], 6'd0});
  assign a_ext   = 18'(a16);

  assign sts.mht_go   = mht_go;
  assign sts.out_free = !out_valid || out_ready;

  function automatic logic signed [23:0] sat_vec(input logic signed [24:0] v);
    logic signed [23:0] r;
    if (v > 25'sd8388607) r = 24'sh7FFFFF;
    else if (v < -25'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  // CORDIC rotation step
  logic [3:0]         si;
  logic signed [27:0] rxs, rys;
  logic signed [17:0] atan_r;
  logic signed [19:0] cx, cy;
  logic [24:0]        x0;

  assign si     = cmd.step[3:0];
  assign rxs    = rx >>> si;
  assign rys    = ry >>> si;
  assign atan_r = signed'({4'd0, jhmd_pkg::atan_step(si)});
  assign cx     = 20'((rx + 28'sd128) >>> 8);
  assign cy     = 20'((ry + 28'sd128) >>> 8);
  assign x0     = 25'(({1'b0, prod} + 33'd128) >> 8);

  // CORDIC vectoring step
  logic signed [34:0] vxs, vys, vx0, vy0;
  logic [15:0]        atan_u;

  assign vxs    = vx >>> si;
  assign vys    = vy >>> si;
  assign atan_u = {2'd0, jhmd_pkg::atan_step(si)};
  assign vx0    = signed'({{3{sum_x[23]}}, sum_x, 8'd0});
  assign vy0    = signed'({{3{sum_y[23]}}, sum_y, 8'd0});

  // square-root digit
  logic [27:0] rem_sh, trial;
  assign rem_sh = {rem, nsh[47:46]};
  assign trial  = {2'd0, root, 2'b01};

  // result assembly
  logic [15:0] zr;
  logic [9:0]  sum_idx;
  logic [24:0] mag;
  logic [3:0]  lk4;
  logic [2:0]  nrep;
  logic [9:0]  dphi [jhmd_pkg::REPORT_JETS];

  assign zr      = vz + 16'd32800;
  assign sum_idx = vzero ? 10'd512 : zr[15:6];
  assign mag     = {1'b0, root} + {24'd0, (rem > {2'd0, root})};
  assign lk4     = 4'(lead_kept);
  assign nrep    = (lk4 > 4'd4) ? 3'd4 : lk4[2:0];

  for (genvar k = 0; k < jhmd_pkg::REPORT_JETS; k++) begin : g_dphi
    if (k < LEAD_JETS) begin : g_on
      logic [9:0] d;
      assign d = sum_idx - lead_phi[k];
      assign dphi[k] = (3'(k) >= nrep) ? 10'd0 :
                       (d > 10'd512)   ? 10'(11'd1024 - {1'b0, d}) : d;
    end else begin : g_off
      assign dphi[k] = 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x          <= '0;
      sum_y          <= '0;
      scalar_sum     <= '0;
      selected_count <= '0;
      items_seen     <= '0;
      lead_kept      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (accept && jet_present) begin
        if (room) begin
          items_seen <= items_seen + 1'b1;
          if (ht_go) begin
            if (selected_count != 7'd127) selected_count <= selected_count + 1'b1;
            scalar_sum <= scalar_add[22] ? jhmd_pkg::SUM_MAX : scalar_add[21:0];
          end
        end else begin
          items_seen <= SEEN_OVER;
        end
      end
      if (cmd.acc) begin
        sum_x <= sat_vec(25'(sum_x) + 25'(cx));
        sum_y <= sat_vec(25'(sum_y) + 25'(cy));
        if (lead_kept < LK_MAX) lead_kept <= lead_kept + 1'b1;
      end
      if (cmd.publish) begin
        sum_x          <= '0;
        sum_y          <= '0;
        scalar_sum     <= '0;
        selected_count <= '0;
        items_seen     <= '0;
        lead_kept      <= '0;
      end
      if (cmd.publish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod  <= jet_pt * jhmd_pkg::PT_GAIN;
      phi_q <= jet_phi;
      // fold into the right half plane
      if (a_ext > 18'sd16384) begin
        neg_q  <= 1'b1;
        a_fold <= a_ext - 18'sd32768;
      end else if (a_ext < -18'sd16384) begin
        neg_q  <= 1'b1;
        a_fold <= a_ext + 18'sd32768;
      end else begin
        neg_q  <= 1'b0;
        a_fold <= a_ext;
      end
    end
    if (cmd.load_rot) begin
      rx <= neg_q ? -signed'({3'd0, x0}) : signed'({3'd0, x0});
      ry <= '0;
      ra <= a_fold;
    end
    if (cmd.step_rot) begin
      if (ra >= 0) begin
        rx <= rx - rys;
        ry <= ry + rxs;
        ra <= ra - atan_r;
      end else begin
        rx <= rx + rys;
        ry <= ry - rxs;
        ra <= ra + atan_r;
      end
    end
    if (cmd.acc && (lead_kept < LK_MAX)) lead_phi[lead_kept[LIDX_W-1:0]] <= phi_q;
    if (cmd.load_vec) begin
      vzero <= (sum_x == 0) && (sum_y == 0);
      sqx   <= sum_x * sum_x;
      if (sum_x[23]) begin
        vx <= -vx0;
        vy <= -vy0;
        vz <= 16'h8000;
      end else begin
        vx <= vx0;
        vy <= vy0;
        vz <= 16'h0000;
      end
    end
    if (cmd.step_vec) begin
      if (vy >= 0) begin
        vx <= vx + vys;
        vy <= vy - vxs;
        vz <= vz + atan_u;
      end else begin
        vx <= vx - vys;
        vy <= vy + vxs;
        vz <= vz - atan_u;
      end
    end
    if (cmd.sq_y) sqy <= sum_y * sum_y;
    if (cmd.load_sqrt) begin
      nsh  <= unsigned'(sqx) + unsigned'(sqy);
      rem  <= '0;
      root <= '0;
    end
    if (cmd.step_sqrt) begin
      nsh <= {nsh[45:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= 26'(rem_sh - trial);
        root <= {root[22:0], 1'b1};
      end else begin
        rem  <= rem_sh[25:0];
        root <= {root[22:0], 1'b0};
      end
    end
    if (cmd.publish) begin
      jet_count     <= selected_count;
      ht_sum        <= scalar_sum;
      mht_magnitude <= (mag > {3'd0, jhmd_pkg::SUM_MAX}) ? jhmd_pkg::SUM_MAX : mag[21:0];
      lead_count    <= nrep;
      dphi_first    <= dphi[0];
      dphi_second   <= dphi[1];
      dphi_third    <= dphi[2];
      dphi_fourth   <= dphi[3];
      overflow      <= items_seen > SEEN_MAX;
    end
  end

endmodule
